[rtl/core/drc_pkg.sv]
// ----------------------------------------------------------------------------
// drc_pkg
// Shared widths, constants and types of the dynamic range compressor.
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int THR_W        = 15;
    localparam int RATIO_W      = 23;
    localparam int GAIN_W       = 16;
    localparam int CH_CODE_W    = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 23;
    localparam int PROD_W       = THR_W + RATIO_W;
    localparam int NUM_W        = PROD_W + 1;
    localparam int DIV_STEPS    = GAIN_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int MAX_CHANNELS = 2;
    localparam int HISTORY_LEN  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd4;

    localparam logic [RATIO_W-1:0]   RATIO_ONE     = 23'd65536;
    localparam logic [GAIN_W-1:0]    GAIN_ONE      = 16'd4096;
    localparam logic [GAIN_W-1:0]    GAIN_MAX      = 16'hFFFF;
    localparam logic [THR_W-1:0]     THR_RESET     = 15'd16384;
    localparam logic [RATIO_W-1:0]   TARGET_RESET  = 23'd262144;
    localparam logic [CH_CODE_W-1:0] CH_RESET      = 2'd2;
    localparam logic [CH_CODE_W-1:0] CH_CODE_ONE   = 2'd1;

    typedef struct packed {
        logic [THR_W-1:0]     threshold_level;
        logic [RATIO_W-1:0]   target_ratio;
        logic [RATIO_W-1:0]   attack_step;
        logic [RATIO_W-1:0]   release_step;
        logic [CH_CODE_W-1:0] active_channels;
    } drc_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRACK,
        S_RAMP,
        S_PROD1,
        S_PROD2,
        S_CHECK,
        S_DIV,
        S_SCALE,
        S_DONE
    } drc_state_t;

    typedef struct packed {
        logic load;
        logic track;
        logic ramp;
        logic prod1;
        logic prod2;
        logic check;
        logic div_step;
        logic scale;
        logic emit;
    } drc_cmd_t;

    typedef struct packed {
        logic bypass;
    } drc_status_t;

endpackage

[rtl/core/drc_cfg.sv]
// ----------------------------------------------------------------------------
// drc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module drc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [drc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output drc_pkg::drc_cfg_t                 cfg
);
    import drc_pkg::*;

    drc_cfg_t cfg_reg;
    drc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: cfg_next.threshold_level = cfg_wdata[THR_W-1:0];
                REG_TARGET:    cfg_next.target_ratio    = cfg_wdata[RATIO_W-1:0];
                REG_ATTACK:    cfg_next.attack_step     = cfg_wdata[RATIO_W-1:0];
                REG_RELEASE:   cfg_next.release_step    = cfg_wdata[RATIO_W-1:0];
                REG_CHANNELS:  cfg_next.active_channels = cfg_wdata[CH_CODE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_level <= THR_RESET;
            cfg_reg.target_ratio    <= TARGET_RESET;
            cfg_reg.attack_step     <= '0;
            cfg_reg.release_step    <= '0;
            cfg_reg.active_channels <= CH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/drc_ctrl.sv]
// ----------------------------------------------------------------------------
// drc_ctrl
// Sequencer that steps the datapath through one frame and runs the handshakes.
// ----------------------------------------------------------------------------
module drc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  drc_pkg::drc_status_t  status,
    output drc_pkg::drc_cmd_t     cmd
);
    import drc_pkg::*;

    drc_state_t             state_reg;
    drc_state_t             state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_TRACK;
            S_TRACK: state_next = S_RAMP;
            S_RAMP:  state_next = S_PROD1;
            S_PROD1: state_next = S_PROD2;
            S_PROD2: state_next = S_CHECK;
            S_CHECK: state_next = status.bypass ? S_SCALE : S_DIV;
            S_DIV:   if (div_cnt_reg == '0) state_next = S_SCALE;
            S_SCALE: state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        s_tready     = 1'b0;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_TRACK: cmd.track = 1'b1;
            S_RAMP:  cmd.ramp  = 1'b1;
            S_PROD1: cmd.prod1 = 1'b1;
            S_PROD2: cmd.prod2 = 1'b1;
            S_CHECK:
            begin
                cmd.check    = 1'b1;
                div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            S_SCALE: cmd.scale = 1'b1;
            S_DONE:  cmd.emit  = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg == '0) |=> (state_reg == S_SCALE))
        else $error("division did not end after its last step");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_TRACK && !s_tready))
        else $error("block took a word without leaving idle");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside the final state");

endmodule

[rtl/core/drc_datapath.sv]
// ----------------------------------------------------------------------------
// drc_datapath
// Averaging, peak tracking, ratio ramp, gain division and channel scaling.
// ----------------------------------------------------------------------------
module drc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  drc_pkg::drc_cfg_t                   cfg,
    input  drc_pkg::drc_cmd_t                   cmd,
    output drc_pkg::drc_status_t                status,
    input  logic signed [drc_pkg::SAMPLE_W-1:0] in_left,
    input  logic signed [drc_pkg::SAMPLE_W-1:0] in_right,
    output logic signed [drc_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [drc_pkg::SAMPLE_W-1:0] out_right,
    output logic [drc_pkg::GAIN_W-1:0]          gain_applied
);
    import drc_pkg::*;

    function automatic logic [SAMPLE_W-1:0] scale_sat(input logic signed [32:0] p);
        logic signed [32:0] biased;
        logic signed [20:0] q;
        biased = p + (p[32] ? 33'sd4095 : 33'sd0);
        q      = biased[32:12];
        if (q > 21'sd32767)
            scale_sat = 16'h7FFF;
        else if (q < -21'sd32768)
            scale_sat = 16'h8000;
        else
            scale_sat = q[SAMPLE_W-1:0];
    endfunction

    logic signed [SAMPLE_W-1:0] left_reg, right_reg;
    logic                       one_ch_reg;
    logic signed [SAMPLE_W-1:0] mid_reg, mid_next;
    logic signed [SAMPLE_W-1:0] old_reg, old_next;
    logic [THR_W-1:0]           amp_reg, amp_next;
    logic [RATIO_W-1:0]         ratio_reg, ratio_next;
    logic [PROD_W-1:0]          tr_reg, tr_next;
    logic [PROD_W-1:0]          den_reg, den_next;
    logic [NUM_W-1:0]           num_reg, num_next;
    logic [PROD_W-1:0]          rem_reg, rem_next;
    logic [GAIN_W-1:0]          low_reg, low_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic signed [32:0]         prod_l_reg, prod_r_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg, out_right_reg;
    logic [GAIN_W-1:0]          gain_out_reg;

    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W:0]   sum_adj;
    logic signed [SAMPLE_W-1:0] avg;
    logic                       extremum;
    logic signed [SAMPLE_W:0]   mag;
    logic [RATIO_W-1:0]         target;
    logic [RATIO_W:0]           ramp_up;
    logic [RATIO_W:0]           rel_floor;
    logic [RATIO_W-1:0]         ratio_eff;
    logic signed [SAMPLE_W-1:0] diff;
    logic signed [NUM_W:0]      num_s;
    logic                       amp_zero;
    logic                       overflow;
    logic [PROD_W:0]            trial;

    // Average, truncated toward zero.
    assign sum      = {left_reg[SAMPLE_W-1], left_reg} + {right_reg[SAMPLE_W-1], right_reg};
    assign sum_adj  = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W] & sum[0]};
    assign avg      = one_ch_reg ? left_reg : sum_adj[SAMPLE_W:1];
    assign extremum = (old_reg < mid_reg && avg < mid_reg) ||
                      (mid_reg < old_reg && mid_reg < avg);
    assign mag      = mid_reg[SAMPLE_W-1] ? -{mid_reg[SAMPLE_W-1], mid_reg}
                                          : {mid_reg[SAMPLE_W-1], mid_reg};

    assign target    = (cfg.target_ratio < RATIO_ONE) ? RATIO_ONE : cfg.target_ratio;
    assign ramp_up   = {1'b0, ratio_reg} + {1'b0, cfg.attack_step};
    assign rel_floor = {1'b0, RATIO_ONE} + {1'b0, cfg.release_step};
    assign ratio_eff = (ratio_reg < RATIO_ONE) ? RATIO_ONE : ratio_reg;

    assign diff  = $signed({1'b0, amp_reg}) - $signed({1'b0, cfg.threshold_level});
    assign num_s = {{(NUM_W - SAMPLE_W - 15){diff[SAMPLE_W-1]}}, diff, 16'd0}
                 + $signed({2'b00, tr_reg});

    assign amp_zero = (amp_reg == '0);
    assign overflow = ({3'b000, num_reg} >= {den_reg, 4'b0000});
    assign status.bypass = amp_zero || overflow;

    assign trial = {rem_reg, low_reg[GAIN_W-1]};

    always_comb
    begin
        mid_next   = mid_reg;
        old_next   = old_reg;
        amp_next   = amp_reg;
        ratio_next = ratio_reg;
        tr_next    = tr_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        gain_next  = gain_reg;

        if (cmd.track)
        begin
            old_next = mid_reg;
            mid_next = avg;
            if (extremum)
                amp_next = mag[SAMPLE_W-1] ? {THR_W{1'b1}} : mag[THR_W-1:0];
        end

        if (cmd.ramp)
        begin
            if (cfg.threshold_level < amp_reg)
            begin
                if (cfg.attack_step == '0)
                    ratio_next = target;
                else if (ramp_up > {1'b0, target})
                    ratio_next = target;
                else
                    ratio_next = ramp_up[RATIO_W-1:0];
            end
            else
            begin
                if (cfg.release_step == '0)
                    ratio_next = RATIO_ONE;
                else if ({1'b0, ratio_reg} < rel_floor)
                    ratio_next = RATIO_ONE;
                else
                    ratio_next = ratio_reg - cfg.release_step;
            end
        end

        if (cmd.prod1)
            tr_next = PROD_W'(cfg.threshold_level) * PROD_W'(ratio_eff);

        if (cmd.prod2)
        begin
            den_next = PROD_W'(ratio_eff) * PROD_W'(amp_reg);
            num_next = num_s[NUM_W] ? '0 : num_s[NUM_W-1:0];
        end

        if (cmd.check)
        begin
            rem_next = PROD_W'(num_reg[NUM_W-1:4]);
            low_next = {num_reg[3:0], 12'd0};
            if (amp_zero)
                gain_next = GAIN_ONE;
            else if (overflow)
                gain_next = GAIN_MAX;
            else
                gain_next = '0;
        end

        if (cmd.div_step)
        begin
            low_next = {low_reg[GAIN_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = PROD_W'(trial - {1'b0, den_reg});
                gain_next = {gain_reg[GAIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[PROD_W-1:0];
                gain_next = {gain_reg[GAIN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg   <= '0;
            old_reg   <= '0;
            amp_reg   <= '0;
            ratio_reg <= RATIO_ONE;
        end
        else
        begin
            mid_reg   <= mid_next;
            old_reg   <= old_next;
            amp_reg   <= amp_next;
            ratio_reg <= ratio_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_reg   <= in_left;
            right_reg  <= in_right;
            one_ch_reg <= (cfg.active_channels == CH_CODE_ONE) || (MAX_CHANNELS < 2);
        end
        tr_reg   <= tr_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        gain_reg <= gain_next;
        if (cmd.scale)
        begin
            prod_l_reg <= 33'(left_reg) * 33'($signed({1'b0, gain_reg}));
            prod_r_reg <= 33'(right_reg) * 33'($signed({1'b0, gain_reg}));
        end
        if (cmd.emit)
        begin
            out_left_reg  <= scale_sat(prod_l_reg);
            out_right_reg <= one_ch_reg ? '0 : scale_sat(prod_r_reg);
            gain_out_reg  <= gain_reg;
        end
    end

    assign out_left     = out_left_reg;
    assign out_right    = out_right_reg;
    assign gain_applied = gain_out_reg;

    a_ratio_floor: assert property (@(posedge clk) disable iff (!rst_n)
        ratio_reg >= RATIO_ONE)
        else $error("compression ratio fell below one");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < den_reg))
        else $error("division remainder not below divisor");

endmodule

[rtl/core/dynamic_range_compressor.sv]
// One word is worked on at a time; when the gain is fixed at unity or at its
// ceiling, the division states are skipped. The gain is formed by a 16-step
// restoring divider, one quotient bit per cycle. The result sits in an output
// register, so the next word is taken meanwhile.
// Reset (rst_n low, asynchronous) loads the register defaults and clears state.
// ----------------------------------------------------------------------------
// dynamic_range_compressor
// Stereo compressor: peak tracking, ramped ratio, divided gain, saturation.
// ----------------------------------------------------------------------------
module dynamic_range_compressor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [drc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*drc_pkg::SAMPLE_W-1:0]      s_tdata,   // sample_left, sample_right
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [3*drc_pkg::SAMPLE_W-1:0]      m_tdata    // out_left, out_right, gain_applied
);
    import drc_pkg::*;

    drc_cfg_t                   cfg;
    drc_cmd_t                   cmd;
    drc_status_t                status;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic [GAIN_W-1:0]          gain_applied;

    drc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    drc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .in_left      (s_tdata[SAMPLE_W-1:0]),
        .in_right     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .out_left     (out_left),
        .out_right    (out_right),
        .gain_applied (gain_applied)
    );

    assign m_tdata = {gain_applied, out_right, out_left};

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dynamic range compressor. A driver streams
// stereo sample words from a queue, with bursts and gaps. A monitor
// compares each output word with the results of an in-bench model of the
// peak tracker, the ratio ramp, the divided gain and the saturating scaler.
// The output side stalls in changing patterns and twice holds off for a long
// stretch. Several register settings are applied between phases, among
// them the extremes.
// ----------------------------------------------------------------------------
module tb_top;

    import drc_pkg::*;

    localparam longint RATIO_UNITY    = RATIO_ONE;
    localparam longint UNITY_GAIN     = GAIN_ONE;
    localparam longint GAIN_CEIL      = GAIN_MAX;
    localparam int     PHASES         = 9;
    localparam int     FRAMES_PER_SET = 137;
    localparam int     SETTLE_CYCLES  = 32;
    localparam int     HOLD_CYCLES    = 600;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     PRINT_LIMIT    = 100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] gain;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } frame_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [2*SAMPLE_W-1:0]   s_tdata = '0;   // sample_left, sample_right
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [3*SAMPLE_W-1:0]   m_tdata;        // out_left, out_right, gain_applied

    logic [THR_W-1:0]        thr_reg = THR_RESET;
    logic [RATIO_W-1:0]      target_reg = TARGET_RESET;
    logic [RATIO_W-1:0]      attack_reg = '0;
    logic [RATIO_W-1:0]      release_reg = '0;
    logic [CH_CODE_W-1:0]    chan_reg = CH_RESET;

    int                      avg_hist [2] = '{0, 0};
    int                      amp_track = 0;
    longint                  ratio_now = RATIO_UNITY;

    logic [2*SAMPLE_W-1:0]   pending_words [$];
    frame_result_t           expected_frames [$];
    frame_result_t           want_frame;

    int                      error_count = 0;
    int                      results_seen = 0;
    int                      burst_left = 0;
    int                      gap_left = 0;
    int                      hold_left = 0;
    int                      stall_mode = 0;
    int                      mode_left = 0;
    int                      idle_cycles = 0;

    dynamic_range_compressor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic logic [SAMPLE_W-1:0] clip16(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic frame_result_t compress_frame(input logic [2*SAMPLE_W-1:0] word);
        int            lv;
        int            rv;
        int            avg;
        int            mid;
        int            old;
        int            mag;
        bit            mono;
        longint        target;
        longint        thr;
        longint        amp;
        longint        atk;
        longint        rel;
        longint        ratio;
        longint        num;
        longint        den;
        longint        gain;
        frame_result_t res;
        lv = $signed(word[SAMPLE_W-1:0]);
        rv = $signed(word[2*SAMPLE_W-1:SAMPLE_W]);
        mono = (chan_reg == CH_CODE_ONE);
        avg = mono ? lv : (lv + rv) / 2;
        mid = avg_hist[0];
        old = avg_hist[1];
        if ((old < mid && avg < mid) || (mid < old && mid < avg))
        begin
            mag = (mid < 0) ? -mid : mid;
            amp_track = (mag > 32767) ? 32767 : mag;
        end
        avg_hist[1] = mid;
        avg_hist[0] = avg;
        target = target_reg;
        if (target < RATIO_UNITY)
            target = RATIO_UNITY;
        thr = thr_reg;
        amp = amp_track;
        atk = attack_reg;
        rel = release_reg;
        if (thr < amp)
        begin
            if (atk == 0 || ratio_now + atk > target)
                ratio_now = target;
            else
                ratio_now = ratio_now + atk;
        end
        else
        begin
            if (rel == 0 || ratio_now < RATIO_UNITY + rel)
                ratio_now = RATIO_UNITY;
            else
                ratio_now = ratio_now - rel;
        end
        ratio = (ratio_now < RATIO_UNITY) ? RATIO_UNITY : ratio_now;
        if (amp == 0)
        begin
            gain = UNITY_GAIN;
        end
        else
        begin
            num = (amp - thr) * RATIO_UNITY + thr * ratio;
            if (num < 0)
                num = 0;
            den = ratio * amp;
            gain = (num * UNITY_GAIN) / den;
            if (gain > GAIN_CEIL)
                gain = GAIN_CEIL;
        end
        res.left = clip16((longint'(lv) * gain) / UNITY_GAIN);
        res.right = mono ? '0 : clip16((longint'(rv) * gain) / UNITY_GAIN);
        res.gain = gain[GAIN_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR: %s", msg);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_THRESHOLD: thr_reg = value[THR_W-1:0];
            REG_TARGET:    target_reg = value[RATIO_W-1:0];
            REG_ATTACK:    attack_reg = value[RATIO_W-1:0];
            REG_RELEASE:   release_reg = value[RATIO_W-1:0];
            REG_CHANNELS:  chan_reg = value[CH_CODE_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int unsigned pick_step();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(1, 4096);
            2:       return $urandom_range(4096, 262144);
            default: return $urandom_range(262144, 8388607);
        endcase
    endfunction

    // Mostly triangle waves of random height and pitch, so that the peak
    // tracker sees clean peaks and valleys; noise and flat runs break them up.
    task automatic queue_frames(input int count);
        int                    added;
        int                    len;
        int                    kind;
        int                    shape;
        int                    peak;
        int                    stride;
        int                    level;
        int                    dir;
        int                    jit;
        int                    r;
        logic [2*SAMPLE_W-1:0] word;
        added = 0;
        word = '0;
        while (added < count)
        begin
            kind = $urandom_range(0, 7);
            len = $urandom_range(6, 40);
            shape = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       peak = $urandom_range(0, 2000);
                1:       peak = $urandom_range(2000, 32767);
                2:       peak = 32767;
                default: peak = int'(thr_reg) + int'($urandom_range(0, 600)) - 300;
            endcase
            if (peak < 0)
                peak = 0;
            if (peak > 32767)
                peak = 32767;
            stride = (2 * peak) / int'($urandom_range(2, 16)) + 1;
            level = int'($urandom_range(0, 2 * peak)) - peak;
            dir = ($urandom_range(0, 1) == 0) ? 1 : -1;
            for (int k = 0; k < len && added < count; k++)
            begin
                if (kind == 0 || (kind == 1 && k == 0))
                begin
                    word = $urandom;
                end
                else if (kind != 1)
                begin
                    level = level + dir * stride;
                    if (level > peak)
                    begin
                        level = peak;
                        dir = -1;
                    end
                    if (level < -peak)
                    begin
                        level = -peak;
                        dir = 1;
                    end
                    jit = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) - 8 : 0;
                    case (shape)
                        0:       r = level - jit;
                        1:       r = -level;
                        2:       r = level / 2;
                        default: r = int'($urandom_range(0, 65535)) - 32768;
                    endcase
                    word = {clip16(r), clip16(level + jit)};
                end
                pending_words.push_back(word);
                added++;
            end
        end
    endtask

    initial
    begin
        int unsigned setting [5];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'h7FFF, 16'h7FFF});
        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'h8000, 16'h8000});
        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'h8000, 16'h7FFF});
        pending_words.push_back({16'h0000, 16'hFFFD});
        pending_words.push_back({16'h0000, 16'h0003});
        pending_words.push_back({16'h4000, 16'h4000});
        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'h4001, 16'h4001});
        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'h1388, 16'h1388});
        pending_words.push_back({16'h1388, 16'h1388});
        pending_words.push_back({16'h1388, 16'h1388});
        pending_words.push_back({16'h7FFF, 16'h8000});
        pending_words.push_back({16'h8000, 16'h7FFF});
        pending_words.push_back({16'hFFFF, 16'h0001});
        pending_words.push_back({16'h0000, 16'h8000});
        pending_words.push_back({16'h0000, 16'h7FFF});
        pending_words.push_back({16'hFFFF, 16'hFFFF});
        pending_words.push_back({16'h7FFF, 16'h0000});
        wait_drained();

        for (int ph = 1; ph <= PHASES; ph++)
        begin
            case (ph)
                1:       setting = '{0, 4194304, 4194304, 0, 2};
                2:       setting = '{32767, 65536, 0, 4194304, 1};
                3:       setting = '{12000, 4194304, 8192, 1024, 2};
                4:       setting = '{4000, 0, 300, 0, 0};
                5:       setting = '{20000, 8388607, 8388607, 8388607, 3};
                default:
                begin
                    setting[0] = $urandom_range(0, 32767);
                    setting[1] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                             : $urandom_range(65536, 4194304);
                    setting[2] = pick_step();
                    setting[3] = pick_step();
                    setting[4] = $urandom_range(0, 3);
                end
            endcase
            write_reg(REG_THRESHOLD, setting[0]);
            write_reg(REG_TARGET, setting[1]);
            write_reg(REG_ATTACK, setting[2]);
            write_reg(REG_RELEASE, setting[3]);
            write_reg(REG_CHANNELS, setting[4]);
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
            queue_frames(FRAMES_PER_SET);
            wait_drained();
        end

        error_count += expected_frames.size();
        if (error_count == 0)
            $display("dynamic_range_compressor verification clean");
        else
            $display("dynamic_range_compressor verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_frames.push_back(compress_frame(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0 || pending_words.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_words.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 60);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_frames.size() == 0)
                begin
                    report_mismatch($sformatf("word %0d arrived with nothing expected",
                                              results_seen));
                end
                else
                begin
                    want_frame = expected_frames.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] !== want_frame.left)
                        report_mismatch($sformatf("word %0d out_left %h, expected %h",
                            results_seen, m_tdata[SAMPLE_W-1:0], want_frame.left));
                    if (m_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want_frame.right)
                        report_mismatch($sformatf("word %0d out_right %h, expected %h",
                            results_seen, m_tdata[2*SAMPLE_W-1:SAMPLE_W], want_frame.right));
                    if (m_tdata[3*SAMPLE_W-1:2*SAMPLE_W] !== want_frame.gain)
                        report_mismatch($sformatf("word %0d gain_applied %h, expected %h",
                            results_seen, m_tdata[3*SAMPLE_W-1:2*SAMPLE_W], want_frame.gain));
                end
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (m_tvalid && m_tready && (results_seen == 200 || results_seen == 800))
            begin
                m_tready <= 1'b0;
                hold_left <= HOLD_CYCLES;
            end
            else
            begin
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 2);
                    mode_left <= $urandom_range(16, 128);
                end
                else
                begin
                    mode_left <= mode_left - 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("dynamic_range_compressor verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
